@@ src/assert_macros.svh @@
// assertion helpers for the checker file hrkd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HRKD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define HRKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/hrkd_pkg.sv @@
`timescale 1ns / 1ps

package hrkd_pkg;

  // key slots of a boot keyboard report that are looked at
  localparam int KeySlots   = 6;
  localparam int SlotW      = (KeySlots > 2) ? $clog2(KeySlots) : 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // commands
  localparam logic [1:0] CmdReport     = 2'd0;
  localparam logic [1:0] CmdTick       = 2'd1;
  localparam logic [1:0] CmdDisconnect = 2'd2;

  // configuration registers
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0]  RegRepeatDelay  = 4'd0;
  localparam logic [CfgIdxW-1:0]  RegRepeatPeriod = 4'd1;
  localparam logic [CfgDataW-1:0] DelayReset      = 16'd400;
  localparam logic [CfgDataW-1:0] PeriodReset     = 16'd60;

  // key codes
  localparam logic [3:0] KeyNone   = 4'd0;
  localparam logic [3:0] KeyNext   = 4'd1;
  localparam logic [3:0] KeyPrev   = 4'd2;
  localparam logic [3:0] KeyEnter  = 4'd3;
  localparam logic [3:0] KeyReturn = 4'd4;
  localparam logic [3:0] KeyEsc    = 4'd5;
  localparam logic [3:0] KeyBksp   = 4'd6;
  localparam logic [3:0] KeyTab    = 4'd7;
  localparam logic [3:0] KeyHome   = 4'd8;
  localparam logic [3:0] KeyEnd    = 4'd9;
  localparam logic [3:0] KeyDel    = 4'd10;
  localparam logic [3:0] KeyRight  = 4'd11;
  localparam logic [3:0] KeyLeft   = 4'd12;
  localparam logic [3:0] KeyDown   = 4'd13;
  localparam logic [3:0] KeyUp     = 4'd14;
  localparam logic [3:0] KeyChar   = 4'd15;

  // report decoding constants
  localparam logic [15:0] UsageNextA   = 16'h00E9;
  localparam logic [15:0] UsageNextB   = 16'h00B5;
  localparam logic [15:0] UsagePrevA   = 16'h00EA;
  localparam logic [15:0] UsagePrevB   = 16'h00B6;
  localparam logic [15:0] UsageEnter   = 16'h00CD;
  localparam logic [7:0]  HybridId     = 8'h01;
  localparam logic [7:0]  HybridLength = 8'd6;
  localparam logic [7:0]  KbdMinLength = 8'd3;
  localparam logic [7:0]  KbdMaxLength = 8'd10;
  localparam logic [7:0]  ShiftMask    = 8'h22;
  localparam logic [7:0]  CapsUsage    = 8'h39;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] report_length;
    logic [7:0] report_id;
    logic       report_is_sensor;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;
  } in_word_t;

  typedef struct packed {
    logic [3:0] key_code;
    logic [6:0] char_code;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ClsKbd,
    ClsHyb,
    ClsCons,
    ClsTick,
    ClsDisc
  } cls_e;

  // classified item handed from front to back
  typedef struct packed {
    cls_e                        cls;
    logic [3:0]                  cons_key;
    logic [SlotW-1:0]            final_step;
    logic [7:0]                  mods;
    logic [KeySlots-1:0][7:0]    slots;
  } item_t;

  typedef struct packed {
    logic [CfgDataW-1:0] repeat_delay;
    logic [CfgDataW-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic [3:0] key;
    logic [6:0] ch;
  } xlat_t;

  // usage code to key / ascii, caps lock toggling is done by the caller
  function automatic xlat_t translate(logic [7:0] code, logic shift, logic caps);
    xlat_t      r;
    logic [7:0] off;
    r.key = KeyNone;
    r.ch  = 7'h00;
    off   = code - 8'h04;
    case (code) inside
      8'h28: r.key = KeyReturn;
      8'h29: r.key = KeyEsc;
      8'h2A: r.key = KeyBksp;
      8'h2B: r.key = KeyTab;
      8'h4A: r.key = KeyHome;
      8'h4B: r.key = KeyEnd;
      8'h4C: r.key = KeyDel;
      8'h4F: r.key = KeyRight;
      8'h50: r.key = KeyLeft;
      8'h51: r.key = KeyDown;
      8'h52: r.key = KeyUp;
      [8'h04:8'h1D]: r.ch = (shift ^ caps) ? 7'(8'h41 + off) : 7'(8'h61 + off);
      8'h1E: r.ch = shift ? 7'h21 : 7'h31;
      8'h1F: r.ch = shift ? 7'h40 : 7'h32;
      8'h20: r.ch = shift ? 7'h23 : 7'h33;
      8'h21: r.ch = shift ? 7'h24 : 7'h34;
      8'h22: r.ch = shift ? 7'h25 : 7'h35;
      8'h23: r.ch = shift ? 7'h5E : 7'h36;
      8'h24: r.ch = shift ? 7'h26 : 7'h37;
      8'h25: r.ch = shift ? 7'h2A : 7'h38;
      8'h26: r.ch = shift ? 7'h28 : 7'h39;
      8'h27: r.ch = shift ? 7'h29 : 7'h30;
      8'h2C: r.ch = 7'h20;
      8'h2D: r.ch = shift ? 7'h5F : 7'h2D;
      8'h2E: r.ch = shift ? 7'h2B : 7'h3D;
      8'h2F: r.ch = shift ? 7'h7B : 7'h5B;
      8'h30: r.ch = shift ? 7'h7D : 7'h5D;
      8'h31: r.ch = shift ? 7'h7C : 7'h5C;
      8'h33: r.ch = shift ? 7'h3A : 7'h3B;
      8'h34: r.ch = shift ? 7'h22 : 7'h27;
      8'h35: r.ch = shift ? 7'h7E : 7'h60;
      8'h36: r.ch = shift ? 7'h3C : 7'h2C;
      8'h37: r.ch = shift ? 7'h3E : 7'h2E;
      8'h38: r.ch = shift ? 7'h3F : 7'h2F;
      default: r.key = KeyNone;
    endcase
    if (r.ch != 7'h00) begin
      r.key = KeyChar;
    end
    return r;
  endfunction

endpackage

@@ src/hid_report_key_decoder_unit.sv @@
`timescale 1ns / 1ps

// HID report to key event decoder.
// in channel (in_valid_i/in_ready_o/in_word_i): one word per report, 1 ms tick
//   or disconnect. out channel (out_valid_o/out_ready_i/out_word_o): key events,
//   last set on the final event caused by one input word. cfg channel writes
//   repeat_delay (index 0) and repeat_period (index 1); it is always ready and
//   should only be used while the block is idle.
// path: with the block idle, an accepted word is written into the queue, then read
//   from the queue into the item register, then one back-end step puts its first
//   event into the output register that drives out_valid_o.
// steps: a keyboard report takes one back-end step per key slot it covers
//   (1 to 6, set by report length), a hybrid report a Next step and a Prev step,
//   every other word one step; dropped reports never reach the back end. one word
//   per cycle enters while the queue has room.
// reset: slots, caps lock, button history, repeat state cleared; delay 400 and
//   period 60 ticks.
// stall: while an event waits in the output register the back end holds its
//   step once it has a further event, the two-entry queue fills, then
//   in_ready_o drops.

module hid_report_key_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  hrkd_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output hrkd_pkg::out_word_t                out_word_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hrkd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hrkd_pkg::CfgDataW-1:0]      cfg_data_i
);

  // configuration registers
  hrkd_pkg::cfg_t cfg_q;

  // front to queue
  logic            keep;
  hrkd_pkg::item_t front_item;
  logic            push;
  logic            q_full;

  // queue to back
  logic            q_empty;
  hrkd_pkg::item_t q_head;
  logic            pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_delay  <= hrkd_pkg::DelayReset;
      cfg_q.repeat_period <= hrkd_pkg::PeriodReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hrkd_pkg::RegRepeatDelay:  cfg_q.repeat_delay  <= cfg_data_i;
        hrkd_pkg::RegRepeatPeriod: cfg_q.repeat_period <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // a word is taken whenever the queue has room, dropped words just vanish
  assign in_ready_o = !q_full;
  assign push       = in_valid_i && in_ready_o && keep;

  hrkd_front u_front (
    .word_i (in_word_i),
    .keep_o (keep),
    .item_o (front_item)
  );

  hrkd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  hrkd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!q_empty),
    .item_i       (q_head),
    .item_pop_o   (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

@@ src/hrkd_front.sv @@
`timescale 1ns / 1ps

module hrkd_front (
  input  hrkd_pkg::in_word_t word_i,
  output logic               keep_o,
  output hrkd_pkg::item_t    item_o
);

  logic [7:0]  rb [8];
  logic [3:0]  nz_flags;
  logic        is_hyb;
  logic        is_kbd;
  logic [15:0] usage;
  logic [3:0]  cons_key;
  logic [7:0]  slot_lim;

  assign rb[0] = word_i.byte_0;
  assign rb[1] = word_i.byte_1;
  assign rb[2] = word_i.byte_2;
  assign rb[3] = word_i.byte_3;
  assign rb[4] = word_i.byte_4;
  assign rb[5] = word_i.byte_5;
  assign rb[6] = word_i.byte_6;
  assign rb[7] = word_i.byte_7;

  assign nz_flags = {rb[5] != 8'h00, rb[4] != 8'h00, rb[3] != 8'h00, rb[2] != 8'h00};
  assign is_hyb   = (word_i.report_id == hrkd_pkg::HybridId)
                 && (word_i.report_length == hrkd_pkg::HybridLength)
                 && ($countones(nz_flags) >= 3);
  assign is_kbd   = (word_i.report_length >= hrkd_pkg::KbdMinLength)
                 && (word_i.report_length <= hrkd_pkg::KbdMaxLength);
  assign usage    = {rb[1], rb[0]};

  always_comb begin
    cons_key = hrkd_pkg::KeyNone;
    if (word_i.report_length == 8'd2 || word_i.report_length == 8'd3) begin
      if (usage == hrkd_pkg::UsageNextA || usage == hrkd_pkg::UsageNextB) begin
        cons_key = hrkd_pkg::KeyNext;
      end else if (usage == hrkd_pkg::UsagePrevA || usage == hrkd_pkg::UsagePrevB) begin
        cons_key = hrkd_pkg::KeyPrev;
      end else if (usage == hrkd_pkg::UsageEnter) begin
        cons_key = hrkd_pkg::KeyEnter;
      end
    end
  end

  // report length capped at 2 + KeySlots, it bounds the slots that are read
  assign slot_lim = (word_i.report_length < 8'(2 + hrkd_pkg::KeySlots))
                  ? word_i.report_length : 8'(2 + hrkd_pkg::KeySlots);

  always_comb begin
    item_o.cons_key   = cons_key;
    item_o.mods       = rb[0];
    item_o.final_step = '0;
    item_o.cls        = hrkd_pkg::ClsKbd;
    for (int j = 0; j < hrkd_pkg::KeySlots; j++) begin
      item_o.slots[j] = rb[2 + j];
    end
    keep_o = 1'b0;
    case (word_i.cmd)
      hrkd_pkg::CmdReport: begin
        if (!word_i.report_is_sensor && word_i.report_length != 8'd0) begin
          if (is_hyb) begin
            keep_o            = 1'b1;
            item_o.cls        = hrkd_pkg::ClsHyb;
            item_o.final_step = hrkd_pkg::SlotW'(1);
          end else if (cons_key != hrkd_pkg::KeyNone) begin
            keep_o     = 1'b1;
            item_o.cls = hrkd_pkg::ClsCons;
          end else if (is_kbd) begin
            keep_o            = 1'b1;
            item_o.cls        = hrkd_pkg::ClsKbd;
            item_o.final_step = hrkd_pkg::SlotW'(slot_lim - 8'd3);
          end
        end
      end
      hrkd_pkg::CmdTick: begin
        keep_o     = 1'b1;
        item_o.cls = hrkd_pkg::ClsTick;
      end
      hrkd_pkg::CmdDisconnect: begin
        keep_o     = 1'b1;
        item_o.cls = hrkd_pkg::ClsDisc;
      end
      default: keep_o = 1'b0;
    endcase
  end

endmodule

@@ src/hrkd_queue.sv @@
`timescale 1ns / 1ps

module hrkd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrkd_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output hrkd_pkg::item_t head_o
);

  hrkd_pkg::item_t               mem_q [hrkd_pkg::QueueDepth];
  logic [hrkd_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [hrkd_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [hrkd_pkg::QCntW-1:0]    count_q, count_d;

  assign full_o  = (count_q == hrkd_pkg::QCntW'(hrkd_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hrkd_pkg::QPtrW'(hrkd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hrkd_pkg::QPtrW'(hrkd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ src/hrkd_back.sv @@
`timescale 1ns / 1ps

module hrkd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hrkd_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  input  hrkd_pkg::item_t     item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrkd_pkg::out_word_t out_word_o
);

  logic                         busy_q;
  logic [hrkd_pkg::SlotW-1:0]   step_q;
  hrkd_pkg::item_t              item_q;

  logic [7:0]  held_q [hrkd_pkg::KeySlots];
  logic [7:0]  held_d [hrkd_pkg::KeySlots];
  logic        caps_q, caps_d;
  logic [1:0]  prior_q, prior_d;
  logic [6:0]  last_char_q, last_char_d;
  logic [7:0]  ru_q, ru_d;
  logic [3:0]  rk_q, rk_d;
  logic [6:0]  rc_q, rc_d;
  logic        ra_q, ra_d;
  logic [15:0] re_q, re_d;
  logic [15:0] re_inc;

  logic                       out_valid_q;
  hrkd_pkg::out_word_t        out_word_q;
  hrkd_pkg::out_word_t        ow;

  logic [hrkd_pkg::KeySlots-1:0] new_key;
  logic [hrkd_pkg::KeySlots-1:0] elig;
  logic [hrkd_pkg::KeySlots-1:0] later;
  logic [7:0]                    primary;
  logic [7:0]                    code;
  logic                          shift;
  hrkd_pkg::xlat_t               xl;
  logic [1:0]                    rise;
  logic                          emit;
  logic                          stall;
  logic                          adv;
  logic                          finishing;

  // per-slot classification against the slots held by the previous keyboard report
  always_comb begin
    for (int j = 0; j < hrkd_pkg::KeySlots; j++) begin
      logic seen;
      logic in_use;
      seen   = 1'b0;
      in_use = (hrkd_pkg::SlotW'(j) <= item_q.final_step);
      for (int k = 0; k < hrkd_pkg::KeySlots; k++) begin
        if (held_q[k] == item_q.slots[j]) begin
          seen = 1'b1;
        end
      end
      new_key[j] = in_use && (item_q.slots[j] != 8'h00) && !seen;
      elig[j]    = new_key[j]
                && (hrkd_pkg::translate(item_q.slots[j], 1'b0, 1'b0).key != hrkd_pkg::KeyNone);
      later[j]   = elig[j] && (hrkd_pkg::SlotW'(j) > step_q);
    end
  end

  // first nonzero slot of the report
  always_comb begin
    primary = 8'h00;
    for (int j = hrkd_pkg::KeySlots - 1; j >= 0; j--) begin
      if (hrkd_pkg::SlotW'(j) <= item_q.final_step && item_q.slots[j] != 8'h00) begin
        primary = item_q.slots[j];
      end
    end
  end

  assign code   = item_q.slots[step_q];
  assign shift  = |(item_q.mods & hrkd_pkg::ShiftMask);
  assign xl     = hrkd_pkg::translate(code, shift, caps_q);
  assign rise   = item_q.mods[1:0] & ~prior_q;
  assign re_inc = (re_q == 16'hFFFF) ? re_q : re_q + 16'd1;

  always_comb begin
    held_d      = held_q;
    caps_d      = caps_q;
    prior_d     = prior_q;
    last_char_d = last_char_q;
    ru_d        = ru_q;
    rk_d        = rk_q;
    rc_d        = rc_q;
    ra_d        = ra_q;
    re_d        = re_q;
    emit        = 1'b0;
    ow.key_code  = hrkd_pkg::KeyNone;
    ow.char_code = last_char_q;
    ow.last      = 1'b1;
    case (item_q.cls)
      hrkd_pkg::ClsKbd: begin
        if (elig[step_q]) begin
          emit        = 1'b1;
          ow.key_code = xl.key;
          ow.last     = ~|later;
          if (xl.key == hrkd_pkg::KeyChar) begin
            last_char_d  = xl.ch;
            ow.char_code = xl.ch;
          end
          ru_d = code;
          rk_d = xl.key;
          rc_d = (xl.key == hrkd_pkg::KeyChar) ? xl.ch : 7'h00;
          ra_d = 1'b0;
          re_d = 16'h0000;
        end
        if (new_key[step_q] && code == hrkd_pkg::CapsUsage) begin
          caps_d = ~caps_q;
        end
        if (step_q == item_q.final_step) begin
          // repeat stops once its key is no longer the primary one
          if (ru_d != 8'h00 && primary != ru_d) begin
            ru_d = 8'h00;
            rk_d = hrkd_pkg::KeyNone;
            rc_d = 7'h00;
            ra_d = 1'b0;
            re_d = 16'h0000;
          end
          for (int j = 0; j < hrkd_pkg::KeySlots; j++) begin
            held_d[j] = (hrkd_pkg::SlotW'(j) <= item_q.final_step) ? item_q.slots[j] : 8'h00;
          end
        end
      end
      hrkd_pkg::ClsHyb: begin
        if (step_q == '0) begin
          emit        = rise[0];
          ow.key_code = hrkd_pkg::KeyNext;
          ow.last     = ~rise[1];
        end else begin
          emit        = rise[1];
          ow.key_code = hrkd_pkg::KeyPrev;
          prior_d     = item_q.mods[1:0];
        end
      end
      hrkd_pkg::ClsCons: begin
        emit        = 1'b1;
        ow.key_code = item_q.cons_key;
      end
      hrkd_pkg::ClsTick: begin
        ow.key_code  = rk_q;
        ow.char_code = rc_q;
        if (ru_q != 8'h00) begin
          re_d = re_inc;
          if (!ra_q) begin
            if (re_inc >= cfg_i.repeat_delay) begin
              ra_d = 1'b1;
              re_d = 16'h0000;
              emit = 1'b1;
            end
          end else if (re_inc >= cfg_i.repeat_period) begin
            re_d = 16'h0000;
            emit = 1'b1;
          end
        end
      end
      hrkd_pkg::ClsDisc: begin
        for (int j = 0; j < hrkd_pkg::KeySlots; j++) begin
          held_d[j] = 8'h00;
        end
        caps_d = 1'b0;
        ru_d   = 8'h00;
        rk_d   = hrkd_pkg::KeyNone;
        rc_d   = 7'h00;
        ra_d   = 1'b0;
        re_d   = 16'h0000;
      end
      default: emit = 1'b0;
    endcase
  end

  assign stall      = emit && out_valid_q && !out_ready_i;
  assign adv        = busy_q && !stall;
  assign finishing  = adv && (step_q == item_q.final_step);
  assign item_pop_o = item_valid_i && (!busy_q || finishing);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      caps_q      <= 1'b0;
      prior_q     <= 2'b00;
      last_char_q <= 7'h00;
      ru_q        <= 8'h00;
      rk_q        <= hrkd_pkg::KeyNone;
      rc_q        <= 7'h00;
      ra_q        <= 1'b0;
      re_q        <= 16'h0000;
      for (int j = 0; j < hrkd_pkg::KeySlots; j++) begin
        held_q[j] <= 8'h00;
      end
    end else begin
      if (item_pop_o) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (finishing) begin
        busy_q <= 1'b0;
      end else if (adv) begin
        step_q <= step_q + 1'b1;
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        held_q      <= held_d;
        caps_q      <= caps_d;
        prior_q     <= prior_d;
        last_char_q <= last_char_d;
        ru_q        <= ru_d;
        rk_q        <= rk_d;
        rc_q        <= rc_d;
        ra_q        <= ra_d;
        re_q        <= re_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q <= item_i;
    end
    if (adv && emit) begin
      out_word_q <= ow;
    end
  end

endmodule

@@ src/hrkd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrkd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input hrkd_pkg::out_word_t out_word_i
);

  `HRKD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "out word dropped while stalled")
  `HRKD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_word_i), "out word changed while stalled")
  `HRKD_ASSERT_SAME(a_key_known, clk_i, rst_ni, out_valid_i, out_word_i.key_code != hrkd_pkg::KeyNone, "event without key code")
  `HRKD_ASSERT_SAME(a_char_set, clk_i, rst_ni, out_valid_i && out_word_i.key_code == hrkd_pkg::KeyChar, out_word_i.char_code != 7'h00, "char event without character")

endmodule

bind hid_report_key_decoder_unit hrkd_checker u_hrkd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);
